// ----- sv/crc32ws_pkg.sv -----
// Shared types, constants and the CRC update matrix for the CRC-32 word stream.
// No dependencies; every module in the block imports this package.
package crc32ws_pkg;

    localparam int unsigned CRC_WIDTH = 32;
    localparam logic [CRC_WIDTH-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [CRC_WIDTH-1:0] SEED_RESET = 32'h5232_5032;
    localparam logic [CRC_WIDTH-1:0] TOP_BIT    = 32'h8000_0000;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] data_word;
        logic                 first_word;
        logic                 last_word;
    } in_item_t;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc_value;
        logic                 crc_final;
    } out_item_t;

    // Row i holds the input bits that XOR into result bit i after 32 shifts.
    typedef logic [CRC_WIDTH-1:0][CRC_WIDTH-1:0] fold_rows_t;

    // Evaluated at elaboration only: push each unit vector through 32 shifts.
    function automatic fold_rows_t fold_rows();
        fold_rows_t           rows;
        logic [CRC_WIDTH-1:0] v;
        rows = '0;
        for (int j = 0; j < CRC_WIDTH; j++)
        begin
            v = TOP_BIT >> (CRC_WIDTH - 1 - j);
            for (int k = 0; k < CRC_WIDTH; k++)
            begin
                if ((v & TOP_BIT) != '0)
                begin
                    v = (v << 1) ^ CRC_POLY;
                end
                else
                begin
                    v = v << 1;
                end
            end
            for (int i = 0; i < CRC_WIDTH; i++)
            begin
                rows[i][j] = v[i];
            end
        end
        return rows;
    endfunction

    localparam fold_rows_t FOLD_ROWS = fold_rows();

endpackage

// ----- sv/crc32ws_fold.sv -----
// Parallel fold of one 32-bit word into the CRC register, MSB first.
// Depends on crc32ws_pkg for the constant update matrix.
module crc32ws_fold (
    input  logic [crc32ws_pkg::CRC_WIDTH-1:0] crc_in,
    input  logic [crc32ws_pkg::CRC_WIDTH-1:0] word_in,
    output logic [crc32ws_pkg::CRC_WIDTH-1:0] crc_out
);
    import crc32ws_pkg::*;

    logic [CRC_WIDTH-1:0] mix;

    assign mix = crc_in ^ word_in;

    // Each result bit is the parity of the mixed word under its matrix row.
    always_comb
    begin
        for (int i = 0; i < CRC_WIDTH; i++)
        begin
            crc_out[i] = ^(mix & FOLD_ROWS[i]);
        end
    end

endmodule

// ----- sv/crc32_word_stream.sv -----
// Running CRC-32 (poly 0x04C11DB7, MSB first, no reflection, no final XOR)
// over a stream of 32-bit words. A transaction is taken into an input register,
// folded by a combinational XOR network and written to a result register, so one
// word is accepted per clock while the output is not stalled; the result is held
// in the result register and leaves once the output is not
// stalled. A word with first_word set
// restarts from the seed register (reset 0x52325032); otherwise the update
// continues from the previous result. The seed is written through cfg_wr_en /
// cfg_wr_data and is used only by first-marked words.
// Depends on crc32ws_pkg and crc32ws_fold.
module crc32_word_stream (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [crc32ws_pkg::CRC_WIDTH-1:0]    cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  crc32ws_pkg::in_item_t                in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output crc32ws_pkg::out_item_t               out_data
);
    import crc32ws_pkg::*;

    logic [CRC_WIDTH-1:0] seed_reg;
    logic [CRC_WIDTH-1:0] crc_reg;
    logic [CRC_WIDTH-1:0] crc_next;
    logic [CRC_WIDTH-1:0] start_crc;
    logic                 stage_valid_reg;
    in_item_t             stage_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    logic                 out_free;
    logic                 stage_move;
    logic                 in_take;

    assign out_free   = !out_valid_reg || !out_stall;
    assign stage_move = stage_valid_reg && out_free;
    assign in_stall   = stage_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;

    assign start_crc = stage_reg.first_word ? seed_reg : crc_reg;

    crc32ws_fold u_fold (
        .crc_in  (start_crc),
        .word_in (stage_reg.data_word),
        .crc_out (crc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= SEED_RESET;
            crc_reg         <= SEED_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            // advance the running CRC only as a word moves to the result register
            if (stage_move)
            begin
                crc_reg <= crc_next;
            end
            if (in_take)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_move)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_reg <= in_data;
        end
        if (stage_move)
        begin
            out_reg.crc_value <= crc_next;
            out_reg.crc_final <= stage_reg.last_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- sv/crc32ws_checker.sv -----
// Port-level assertions for crc32_word_stream, attached by the bind below.
// Depends on crc32ws_pkg for the payload types.
module crc32ws_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [crc32ws_pkg::CRC_WIDTH-1:0] cfg_wr_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  crc32ws_pkg::in_item_t             in_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  crc32ws_pkg::out_item_t            out_data
);
    import crc32ws_pkg::*;

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // stall the input only when a result is blocked downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // move an accepted transaction into the result register when not blocked
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted transaction did not reach the output");

    // invent nothing; with input idle and output free, a result leaves once
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && out_valid && !out_stall && !in_stall ##1 !in_valid && !out_stall
        |=> !out_valid)
        else $error("result appeared without an accepted transaction");

endmodule

bind crc32_word_stream crc32ws_checker u_crc32ws_checker (.*);

// ----- test/tb_crc32_word_stream.sv -----
// Self-checking testbench for crc32_word_stream: running CRC-32 over word messages.
// Drives random and directed word streams with random pacing and checks every result.
// Depends on crc32ws_pkg and the crc32_word_stream RTL.
`timescale 1ns / 1ps

module tb_crc32_word_stream;

    import crc32ws_pkg::*;

    typedef enum int {
        PACE_SLOW_RX,
        PACE_SLOW_TX,
        PACE_FULL
    } pace_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_HOLD  = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 155;
    localparam int MAX_REPORTS    = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CRC_WIDTH-1:0]  cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    in_item_t              pending_words[$];
    out_item_t             crc_expected[$];

    logic [CRC_WIDTH-1:0]  seed_model;
    logic [CRC_WIDTH-1:0]  crc_model;
    pace_t                 pace = PACE_FULL;
    bit                    pressure_arm = 1'b0;
    int                    hold_left = 0;
    bit                    in_taken = 1'b0;
    int                    quiet_cycles = 0;
    int                    mismatches = 0;
    int                    words_in = 0;
    int                    results_checked = 0;
    int                    seeds_written = 0;

    crc32_word_stream dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Fold one word into the CRC, most significant bit first.
    function automatic logic [CRC_WIDTH-1:0] crc_fold(logic [CRC_WIDTH-1:0] crc,
                                                      logic [CRC_WIDTH-1:0] word);
        logic [CRC_WIDTH-1:0] r;
        r = crc ^ word;
        for (int k = 0; k < CRC_WIDTH; k++)
        begin
            r = ((r & TOP_BIT) != '0) ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Sender: advance to the next transaction once the current one is taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (rst_n && pending_words.size() != 0 &&
                $urandom_range(99) >= (pace == PACE_SLOW_RX ? 11 :
                                       pace == PACE_SLOW_TX ? 57 : 0))
            begin
                in_data  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold to back up the pipeline.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_arm)
        begin
            pressure_arm = 1'b0;
            out_stall    <= 1'b1;
            hold_left    <= PRESSURE_HOLD - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < (pace == PACE_SLOW_RX ? 57 :
                                                pace == PACE_SLOW_TX ? 11 : 0));
        end
    end

    always @(posedge clk)
    begin : monitor
        logic [CRC_WIDTH-1:0] start;
        out_item_t            want;
        bit                   in_fire;
        bit                   out_fire;

        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        in_taken <= in_fire;

        if (in_fire)
        begin
            start          = in_data.first_word ? seed_model : crc_model;
            crc_model      = crc_fold(start, in_data.data_word);
            want.crc_value = crc_model;
            want.crc_final = in_data.last_word;
            crc_expected.push_back(want);
            words_in++;
        end

        if (out_fire)
        begin
            if (crc_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result crc=%08h final=%0b", $realtime,
                             out_data.crc_value, out_data.crc_final);
            end
            else
            begin
                want = crc_expected.pop_front();
                results_checked++;
                if (out_data.crc_value !== want.crc_value ||
                    out_data.crc_final !== want.crc_final)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected crc=%08h final=%0b,",
                                  " got crc=%08h final=%0b"},
                                 $realtime, want.crc_value, want.crc_final,
                                 out_data.crc_value, out_data.crc_final);
                end
            end
        end

        quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("tb_crc32_word_stream: FAIL");
            $finish;
        end
    end

    task automatic queue_word(logic [CRC_WIDTH-1:0] word, bit first, bit last);
        in_item_t item;
        item.data_word  = word;
        item.first_word = first;
        item.last_word  = last;
        pending_words.push_back(item);
    endtask

    function automatic logic [CRC_WIDTH-1:0] rand_word();
        int unsigned bitpos;
        bitpos = $urandom_range(CRC_WIDTH - 1);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return TOP_BIT >> bitpos;
            3: return ~(TOP_BIT >> bitpos);
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed messages; the rest carry random first/last marks.
    task automatic queue_messages(int count);
        int  len;
        bit  broken;
        while (count > 0)
        begin
            len    = $urandom_range(1, 8);
            broken = ($urandom_range(99) < 15);
            for (int i = 0; i < len && count > 0; i++)
            begin
                if (broken)
                    queue_word(rand_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                    queue_word(rand_word(), i == 0, i == len - 1);
                count--;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || crc_expected.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic write_seed(logic [CRC_WIDTH-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        seed_model  = value;
        seeds_written++;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CRC_WIDTH-1:0] phase_seed[PHASES];
        pace_t                phase_pace[PHASES];

        phase_seed = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom,
                       32'h8000_0000, 32'h0000_0001, $urandom};
        phase_pace = '{PACE_SLOW_RX, PACE_SLOW_RX, PACE_SLOW_TX,
                       PACE_SLOW_TX, PACE_FULL, PACE_FULL};

        seed_model = SEED_RESET;
        crc_model  = SEED_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: continue from the reset seed, no reload after a last word,
        // single-word messages, bit extremes. Leave the last message open.
        @(posedge clk);
        pace = PACE_SLOW_RX;
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b1);
        queue_word(32'h0000_0001, 1'b0, 1'b0);
        queue_word(32'h0000_0000, 1'b1, 1'b1);
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        queue_word(32'h5555_5555, 1'b0, 1'b1);
        queue_word(32'h8000_0000, 1'b1, 1'b1);
        queue_word(32'h0000_0001, 1'b1, 1'b0);
        queue_word(32'h1234_5678, 1'b0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_word(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_word(32'hFEFE_FEFE, 1'b0, 1'b1);
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'h5232_5032, 1'b1, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_seed(phase_seed[p]);
            @(posedge clk);
            pace = phase_pace[p];
            // The open message carries on past the seed change.
            queue_word(rand_word(), 1'b0, 1'b0);
            queue_messages(PHASE_WORDS);
            if (p == 4)
                pressure_arm = 1'b1;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d CRC results from %0d words under %0d seed settings,",
                 results_checked, words_in, seeds_written);
        $display("three pacing modes and one long output hold; %0d mismatches.", mismatches);
        if (mismatches == 0 && crc_expected.size() == 0)
            $display("tb_crc32_word_stream: PASS");
        else
            $display("tb_crc32_word_stream: FAIL");
        $finish;
    end

endmodule
